### src/light_sensor_autogain_reader_defines.svh
// assertion macros for the light sensor auto-gain reader checker
// expects clk_i and rst_ni in scope where the macros are used
`ifndef LIGHT_SENSOR_AUTOGAIN_READER_DEFINES_SVH
`define LIGHT_SENSOR_AUTOGAIN_READER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LSAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lsar_pkg.sv
// shared types and constants for the light sensor auto-gain reader
// no dependencies
package lsar_pkg;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  // sensor registers and field constants
  localparam logic [7:0]  GAIN_REG          = 8'h02;
  localparam logic [7:0]  HIGH_REG          = 8'h04;
  localparam logic [7:0]  LOW_REG           = 8'h05;
  localparam int unsigned OVERFLOW_BIT      = 6;
  localparam logic [15:0] FULL_SCALE        = 16'd16383;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd10;
  localparam logic [7:0]  FAIL_COUNT_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_XFER_DONE = 2'd1,
    OP_WAIT_DONE = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WAIT  = 3'd2,
    ACT_OK    = 3'd3,
    ACT_FAIL  = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WRITE  = 4'd1,
    PH_SETTLE = 4'd2,
    PH_HIGH   = 4'd3,
    PH_LOW    = 4'd4,
    PH_RETRY  = 4'd5
  } phase_e;

  typedef enum logic {
    WAIT_LONG  = 1'b0,
    WAIT_SHORT = 1'b1
  } wait_kind_e;

  // one incoming event
  typedef struct packed {
    logic [1:0] opcode;
    logic       xfer_ok;
    logic [7:0] read_data;
  } event_t;

  // one outgoing command or result
  typedef struct packed {
    action_e     action;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic        wait_kind;
    logic [15:0] lux;
    logic [1:0]  gain_step;
  } result_t;

endpackage

### src/lsar_in_stage.sv
// input register of the event stream
// depends on lsar_pkg
module lsar_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsar_pkg::IN_DATA_W-1:0] s_axis_tdata,  // read_data[7:0]
  input  logic [lsar_pkg::IN_USER_W-1:0] s_axis_tuser,  // opcode[1:0], xfer_ok[2]
  input  logic                           adv_i,
  output logic                           ev_valid_o,
  output lsar_pkg::event_t               ev_o
);
  import lsar_pkg::*;

  logic   valid_q;
  event_t ev_q;

  assign s_axis_tready = !valid_q || adv_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // payload, loaded on each transfer
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev_q.opcode    <= s_axis_tuser[1:0];
      ev_q.xfer_ok   <= s_axis_tuser[2];
      ev_q.read_data <= s_axis_tdata;
    end
  end

  assign ev_valid_o = valid_q;
  assign ev_o       = ev_q;

endmodule

### src/lsar_core.sv
// measurement sequencer: state registers and next command logic
// depends on lsar_pkg
module lsar_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              step_i,
  input  lsar_pkg::event_t  ev_i,
  output logic              res_valid_o,
  output lsar_pkg::result_t res_o
);
  import lsar_pkg::*;

  logic [7:0]  retry_limit_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  gain_q, gain_d;
  logic [7:0]  fail_q, fail_d;
  logic [5:0]  high_q, high_d;
  logic        wr_ok_q, wr_ok_d;

  logic [7:0]  fail_inc;
  logic        give_up;
  logic [13:0] raw;
  logic [15:0] lux_scaled;
  logic [2:0]  gain_up;
  result_t     res;
  logic        res_vld;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      retry_limit_q <= cfg_data_i;
    end
  end

  // saturating failure count and give-up test
  assign fail_inc = (fail_q != FAIL_COUNT_MAX) ? fail_q + 8'd1 : fail_q;
  assign give_up  = fail_inc > retry_limit_q;
  assign gain_up  = gain_q + 3'd1;

  // raw reading scaled by gain step
  assign raw = {high_q, ev_i.read_data};
  always_comb begin
    case (gain_q)
      3'd0:    lux_scaled = {7'b0, raw[13:5]};
      3'd1:    lux_scaled = {5'b0, raw[13:3]};
      3'd2:    lux_scaled = {3'b0, raw[13:1]};
      default: lux_scaled = {raw, 2'b00};
    endcase
  end

  // next state and command
  always_comb begin
    phase_d = phase_q;
    gain_d  = gain_q;
    fail_d  = fail_q;
    high_d  = high_q;
    wr_ok_d = wr_ok_q;
    res     = '0;
    res_vld = 1'b0;

    case (ev_i.opcode)
      OP_START: begin
        gain_d         = 3'd0;
        fail_d         = 8'd0;
        phase_d        = PH_WRITE;
        res.action     = ACT_WRITE;
        res.reg_addr   = GAIN_REG;
        res_vld        = 1'b1;
      end
      OP_XFER_DONE: begin
        case (phase_q)
          PH_WRITE: begin
            wr_ok_d    = ev_i.xfer_ok;
            phase_d    = PH_SETTLE;
            res.action = ACT_WAIT;
            res_vld    = 1'b1;
          end
          PH_HIGH: begin
            res_vld = 1'b1;
            if (!ev_i.xfer_ok) begin
              fail_d = fail_inc;
              if (give_up) begin
                phase_d    = PH_IDLE;
                res.action = ACT_FAIL;
              end else begin
                phase_d       = PH_RETRY;
                res.action    = ACT_WAIT;
                res.wait_kind = WAIT_SHORT;
              end
            end else if (ev_i.read_data[OVERFLOW_BIT]) begin
              gain_d = gain_up;
              if (gain_up[2]) begin
                phase_d    = PH_IDLE;
                res.action = ACT_OK;
                res.lux    = FULL_SCALE;
              end else begin
                phase_d        = PH_WRITE;
                res.action     = ACT_WRITE;
                res.reg_addr   = GAIN_REG;
                res.write_data = {6'b0, gain_up[1:0]};
              end
            end else begin
              high_d       = ev_i.read_data[5:0];
              phase_d      = PH_LOW;
              res.action   = ACT_READ;
              res.reg_addr = LOW_REG;
            end
          end
          PH_LOW: begin
            res_vld = 1'b1;
            if (!ev_i.xfer_ok) begin
              fail_d = fail_inc;
              if (give_up) begin
                phase_d    = PH_IDLE;
                res.action = ACT_FAIL;
              end else begin
                phase_d       = PH_RETRY;
                res.action    = ACT_WAIT;
                res.wait_kind = WAIT_SHORT;
              end
            end else begin
              phase_d    = PH_IDLE;
              res.action = ACT_OK;
              res.lux    = lux_scaled;
            end
          end
          default: ;
        endcase
      end
      OP_WAIT_DONE: begin
        if (phase_q == PH_SETTLE) begin
          res_vld = 1'b1;
          if (!wr_ok_q) begin
            fail_d = fail_inc;
            if (give_up) begin
              phase_d    = PH_IDLE;
              res.action = ACT_FAIL;
            end else begin
              phase_d       = PH_RETRY;
              res.action    = ACT_WAIT;
              res.wait_kind = WAIT_SHORT;
            end
          end else begin
            phase_d      = PH_HIGH;
            res.action   = ACT_READ;
            res.reg_addr = HIGH_REG;
          end
        end else if (phase_q == PH_RETRY) begin
          gain_d       = 3'd0;
          phase_d      = PH_WRITE;
          res.action   = ACT_WRITE;
          res.reg_addr = GAIN_REG;
          res_vld      = 1'b1;
        end
      end
      default: ;
    endcase

    // gain step reported with every result, capped at step 3
    res.gain_step = gain_d[2] ? 2'd3 : gain_d[1:0];
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      gain_q  <= 3'd0;
      fail_q  <= 8'd0;
      high_q  <= 6'd0;
      wr_ok_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      gain_q  <= gain_d;
      fail_q  <= fail_d;
      high_q  <= high_d;
      wr_ok_q <= wr_ok_d;
    end
  end

  assign res_valid_o = res_vld;
  assign res_o       = res;

endmodule

### src/lsar_out_stage.sv
// result register driving the command stream
// depends on lsar_pkg
module lsar_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            res_valid_i,
  input  lsar_pkg::result_t               res_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // reg_addr[7:0], write_data[15:8], wait_kind[16], lux[32:17], gain_step[34:33]
  output logic [lsar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [lsar_pkg::OUT_USER_W-1:0] m_axis_tuser   // action[2:0]
);
  import lsar_pkg::*;

  logic    valid_q;
  result_t res_q;

  // valid flag: set by a new result, cleared by a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.action;
  assign m_axis_tdata  = {5'b0, res_q.gain_step, res_q.lux, res_q.wait_kind,
                          res_q.write_data, res_q.reg_addr};

endmodule

### src/light_sensor_autogain_reader.sv
// Light sensor auto-gain reader: sequences one auto-ranging measurement.
// Event stream in (s_axis): tuser carries the opcode (start, transfer done,
// wait done) and the transfer-ok flag, tdata the byte returned by a read.
// Command stream out (m_axis): tuser carries the action (write, read, wait,
// finished ok, finished failed), tdata the register address, write data,
// wait kind, scaled reading and gain step in use.
// Configuration: cfg_valid_i/cfg_data_i load the retry limit; always ready.
// Path: an event transfer goes into the input register, then its command into
// the result register, which drives m_axis_tvalid. Throughput is one event
// per cycle while the result register is free or being drained; the
// sequencer state updates in the single step between the two registers.
// Events that call for no command (completions with nothing pending,
// reserved opcode) update nothing and produce no transfer.
// Reset: both stream registers empty, sequencer idle, retry limit 10.
// Stall: while a command waits for m_axis_tready, one more event is held in
// the input register, after which s_axis_tready drops.
// depends on lsar_pkg, lsar_in_stage, lsar_core, lsar_out_stage
module light_sensor_autogain_reader (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [7:0]                      cfg_data_i,     // retry_limit[7:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lsar_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // read_data[7:0]
  input  logic [lsar_pkg::IN_USER_W-1:0]  s_axis_tuser,   // opcode[1:0], xfer_ok[2]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // reg_addr[7:0], write_data[15:8], wait_kind[16], lux[32:17], gain_step[34:33]
  output logic [lsar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [lsar_pkg::OUT_USER_W-1:0] m_axis_tuser    // action[2:0]
);
  import lsar_pkg::*;

  logic    ev_valid;
  event_t  ev;
  logic    step;
  logic    res_valid;
  result_t res;

  assign cfg_ready_o = 1'b1;

  // an event moves on when the result register is free or being drained
  assign step = ev_valid && (!m_axis_tvalid || m_axis_tready);

  lsar_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .adv_i        (step),
    .ev_valid_o   (ev_valid),
    .ev_o         (ev)
  );

  lsar_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .ev_i       (ev),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  lsar_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

### src/lsar_checker.sv
// port-level checks for the light sensor auto-gain reader, bound to the top
// depends on lsar_pkg and light_sensor_autogain_reader_defines.svh
`include "light_sensor_autogain_reader_defines.svh"

module lsar_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lsar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [lsar_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import lsar_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled command holds
  `LSAR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled command changed")

  // with the result register empty the input register drains, so input is ready
  `LSAR_ASSERT_NOW(a_in_ready, !m_axis_tvalid, s_axis_tready,
    "input not ready while output empty")

  // no command appears without an event accepted shortly before
  `LSAR_ASSERT_NEXT(a_no_spurious,
    !m_axis_tvalid && !in_xfer ##1 !m_axis_tvalid && !in_xfer, !m_axis_tvalid,
    "command without a source event")

  // gain writes target the gain register with the reported gain step
  `LSAR_ASSERT_NOW(a_write_fields, m_axis_tvalid && m_axis_tuser == ACT_WRITE,
    m_axis_tdata[7:0] == GAIN_REG && m_axis_tdata[15:10] == 6'd0 &&
    m_axis_tdata[9:8] == m_axis_tdata[34:33],
    "gain write fields inconsistent")

endmodule

bind light_sensor_autogain_reader lsar_checker u_lsar_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### tb/tb_light_sensor_autogain_reader.sv
// self-checking testbench for the light sensor auto-gain reader sequencer
// depends on lsar_pkg and light_sensor_autogain_reader
`timescale 1ns / 1ps

module tb_light_sensor_autogain_reader;
  import lsar_pkg::*;

  // opcode outside the defined set, must be ignored by the block
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;

  // tracks the measurement sequence and holds the commands still owed
  class readout_tracker;
    phase_e      phase;
    logic [2:0]  gain_level;
    logic [7:0]  fail_count;
    logic [7:0]  retry_limit;
    logic [5:0]  high_bits;
    logic        write_ok;
    result_t     owed_cmds[$];
    int unsigned errors;

    function new();
      phase       = PH_IDLE;
      gain_level  = '0;
      fail_count  = '0;
      retry_limit = RETRY_LIMIT_RESET;
      high_bits   = '0;
      write_ok    = 1'b0;
      errors      = 0;
    endfunction

    function void owe(action_e act, logic [7:0] addr, logic [7:0] wdata, logic wk,
                      logic [15:0] lux);
      result_t r;
      r.action     = act;
      r.reg_addr   = addr;
      r.write_data = wdata;
      r.wait_kind  = wk;
      r.lux        = lux;
      r.gain_step  = (gain_level > 3'd3) ? 2'd3 : gain_level[1:0];
      owed_cmds.push_back(r);
    endfunction

    function void command_gain_write();
      phase = PH_WRITE;
      owe(ACT_WRITE, GAIN_REG, {6'd0, gain_level[1:0]}, WAIT_LONG, 16'd0);
    endfunction

    // failed transfer: give up past the limit, otherwise short wait and retry
    function void count_failure();
      if (fail_count != FAIL_COUNT_MAX) fail_count++;
      if (fail_count > retry_limit) begin
        phase = PH_IDLE;
        owe(ACT_FAIL, 8'd0, 8'd0, WAIT_LONG, 16'd0);
      end else begin
        phase = PH_RETRY;
        owe(ACT_WAIT, 8'd0, 8'd0, WAIT_SHORT, 16'd0);
      end
    endfunction

    // advance on one accepted event, returns 1 when a command is owed
    function bit note_event(event_t ev);
      logic [13:0] raw;
      logic [15:0] lux;
      int unsigned queued;
      queued = owed_cmds.size();
      case (ev.opcode)
        OP_START: begin
          gain_level = '0;
          fail_count = '0;
          command_gain_write();
        end
        OP_XFER_DONE: begin
          case (phase)
            PH_WRITE: begin
              write_ok = ev.xfer_ok;
              phase    = PH_SETTLE;
              owe(ACT_WAIT, 8'd0, 8'd0, WAIT_LONG, 16'd0);
            end
            PH_HIGH: begin
              if (!ev.xfer_ok) begin
                count_failure();
              end else if (ev.read_data[OVERFLOW_BIT]) begin
                gain_level = gain_level + 3'd1;
                if (gain_level >= 3'd4) begin
                  phase = PH_IDLE;
                  owe(ACT_OK, 8'd0, 8'd0, WAIT_LONG, FULL_SCALE);
                end else begin
                  command_gain_write();
                end
              end else begin
                high_bits = ev.read_data[5:0];
                phase     = PH_LOW;
                owe(ACT_READ, LOW_REG, 8'd0, WAIT_LONG, 16'd0);
              end
            end
            PH_LOW: begin
              if (!ev.xfer_ok) begin
                count_failure();
              end else begin
                raw = {high_bits, ev.read_data};
                case (gain_level)
                  3'd0:    lux = {7'd0, raw[13:5]};
                  3'd1:    lux = {5'd0, raw[13:3]};
                  3'd2:    lux = {3'd0, raw[13:1]};
                  default: lux = {raw, 2'b00};
                endcase
                phase = PH_IDLE;
                owe(ACT_OK, 8'd0, 8'd0, WAIT_LONG, lux);
              end
            end
            default: ;
          endcase
        end
        OP_WAIT_DONE: begin
          if (phase == PH_SETTLE) begin
            if (!write_ok) begin
              count_failure();
            end else begin
              phase = PH_HIGH;
              owe(ACT_READ, HIGH_REG, 8'd0, WAIT_LONG, 16'd0);
            end
          end else if (phase == PH_RETRY) begin
            gain_level = '0;
            command_gain_write();
          end
        end
        default: ;
      endcase
      return owed_cmds.size() != queued;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // match one command transfer against the oldest owed command
    function void check_command(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
      result_t want;
      if (owed_cmds.size() == 0) begin
        $error("command transfer with none owed: action 0x%0h data 0x%0h", user, data);
        errors++;
        return;
      end
      want = owed_cmds.pop_front();
      compare_field("action", want.action, user);
      compare_field("reg_addr", want.reg_addr, data[7:0]);
      compare_field("write_data", want.write_data, data[15:8]);
      compare_field("wait_kind", want.wait_kind, data[16]);
      compare_field("lux", want.lux, data[32:17]);
      compare_field("gain_step", want.gain_step, data[34:33]);
      compare_field("tdata padding", 0, data[OUT_DATA_W-1:35]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [7:0]            cfg_data;
  logic                  s_valid;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data;
  logic [IN_USER_W-1:0]  s_user;
  logic                  m_valid;
  logic                  m_ready;
  logic [OUT_DATA_W-1:0] m_data;
  logic [OUT_USER_W-1:0] m_user;

  readout_tracker tracker = new();

  // stimulus knobs, changed per phase
  bit quiet_idle  = 1'b0;
  bit hold_off    = 1'b0;
  int noise_pct   = 15;
  int fail_pct    = 10;
  int ovf_pct     = 40;

  light_sensor_autogain_reader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always #1 clk_i = ~clk_i;

  // command transfers are checked as they happen
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) tracker.check_command(m_user, m_data);
  end

  // mostly short stalls, a few long ones
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_gap();
    if (quiet_idle || $urandom_range(0, 99) < 60) return 0;
    return stall_len();
  endfunction

  // receiver side: random back-pressure plus the requested long hold-off
  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        m_ready <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (quiet_idle || $urandom_range(0, 3) != 0) begin
        m_ready <= 1'b1;
        @(negedge clk_i);
      end else begin
        m_ready <= 1'b0;
        repeat (stall_len()) @(negedge clk_i);
      end
    end
  end

  function automatic event_t mk(logic [1:0] op, logic ok, logic [7:0] byte_val);
    event_t ev;
    ev.opcode    = op;
    ev.xfer_ok   = ok;
    ev.read_data = byte_val;
    return ev;
  endfunction

  // mostly the event the sequencer is waiting for, sometimes noise
  function automatic event_t next_event();
    event_t ev;
    ev = mk(OP_START, 1'b1, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < noise_pct) begin
      ev.opcode  = 2'($urandom_range(0, 3));
      ev.xfer_ok = 1'($urandom_range(0, 1));
      return ev;
    end
    ev.xfer_ok = ($urandom_range(0, 99) >= fail_pct);
    case (tracker.phase)
      PH_IDLE:                   ev.opcode = OP_START;
      PH_WRITE, PH_HIGH, PH_LOW: ev.opcode = OP_XFER_DONE;
      default:                   ev.opcode = OP_WAIT_DONE;
    endcase
    if (tracker.phase == PH_HIGH)
      ev.read_data[OVERFLOW_BIT] = ($urandom_range(0, 99) < ovf_pct);
    return ev;
  endfunction

  // one event transfer; called at a falling edge, returns at a falling edge
  task automatic send_event(event_t ev, int gap, output bit owed);
    repeat (gap) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ev.read_data;
    s_user  <= {ev.xfer_ok, ev.opcode};
    do @(posedge clk_i); while (!s_ready);
    owed = tracker.note_event(ev);
    @(negedge clk_i);
  endtask

  // drop input valid, pause until every owed command is out, then let the block settle
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (tracker.owed_cmds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_retry_limit(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.retry_limit = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_script(event_t script[$]);
    bit owed;
    foreach (script[i]) send_event(script[i], pick_gap(), owed);
  endtask

  // random events until enough commands have been owed
  task automatic run_phase(int wanted, int hold_at, int pause_at);
    int got;
    bit owed;
    got = 0;
    while (got < wanted) begin
      if (got == hold_at) hold_off = 1'b1;
      if (got == pause_at) wait_idle();
      send_event(next_event(), pick_gap(), owed);
      if (owed) got++;
    end
  endtask

  initial begin
    event_t script[$];
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // events with nothing pending and the reserved opcode
    script.push_back(mk(OP_XFER_DONE, 1'b1, 8'hFF));
    script.push_back(mk(OP_WAIT_DONE, 1'b0, 8'h00));
    script.push_back(mk(OP_RESERVED, 1'b1, 8'hAA));
    // plain measurement at gain step 0, largest raw value
    script.push_back(mk(OP_START, 1'b0, 8'h00));
    script.push_back(mk(OP_XFER_DONE, 1'b1, 8'h00));
    script.push_back(mk(OP_WAIT_DONE, 1'b1, 8'h00));
    script.push_back(mk(OP_XFER_DONE, 1'b1, 8'h3F));
    script.push_back(mk(OP_XFER_DONE, 1'b1, 8'hFF));
    // overflow at every gain step ends in full scale
    script.push_back(mk(OP_START, 1'b1, 8'h00));
    for (int g = 0; g < 4; g++) begin
      script.push_back(mk(OP_XFER_DONE, 1'b1, 8'h00));
      script.push_back(mk(OP_WAIT_DONE, 1'b1, 8'h00));
      script.push_back(mk(OP_XFER_DONE, 1'b1, 8'hC0));
    end
    // write failure, retry wait, restart, then a start while busy
    script.push_back(mk(OP_START, 1'b1, 8'h00));
    script.push_back(mk(OP_XFER_DONE, 1'b0, 8'h00));
    script.push_back(mk(OP_WAIT_DONE, 1'b1, 8'h00));
    script.push_back(mk(OP_WAIT_DONE, 1'b1, 8'h00));
    script.push_back(mk(OP_START, 1'b1, 8'h00));
    run_script(script);

    // default limit, with a long receiver hold-off and a mid-phase drain
    run_phase(130, 50, 95);
    wait_idle();

    // give up on the first failure
    set_retry_limit(8'd0);
    fail_pct = 15;
    run_phase(70, -1, -1);
    wait_idle();

    // never give up: every transfer fails and the count keeps climbing
    set_retry_limit(8'd255);
    noise_pct = 0;
    fail_pct  = 100;
    run_phase(120, -1, -1);
    fail_pct = 10;
    run_phase(20, -1, -1);
    wait_idle();

    // random limit with both sides running flat out
    set_retry_limit(8'($urandom_range(1, 254)));
    noise_pct  = 15;
    quiet_idle = 1'b1;
    run_phase(70, -1, -1);
    wait_idle();

    // small limit, frequent failures
    set_retry_limit(8'd3);
    quiet_idle = 1'b0;
    fail_pct   = 25;
    run_phase(90, -1, -1);

    wait_idle();
    if (tracker.errors == 0 && tracker.owed_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
